>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, active during reset as well
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/fwsw_pkg.sv
// Types, constants and fixed-point helpers of the f-wave shallow water solver
package fwsw_pkg;

    localparam int FRAC_BITS = 16;
    localparam int GAP_MIN   = ((1 << FRAC_BITS) + 50) / 100;
    localparam logic [30:0] GRAVITY_RESET = 31'd642908;

    localparam int SQ_STEPS = (31 + FRAC_BITS + 1) / 2;
    localparam int DIV_W    = 32 + FRAC_BITS;

    localparam int FRONT_STG = 8;
    localparam int MID1_STG  = 4;
    localparam int MID2_STG  = 6;
    localparam int TAIL_STG  = 5;
    localparam int PIPE_STG  = FRONT_STG + SQ_STEPS + MID1_STG + DIV_W + MID2_STG + DIV_W
                               + TAIL_STG;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEPTH = 2'd1;
    localparam logic [1:0] STATUS_SMALL_GAP  = 2'd2;

    localparam logic signed [65:0] S32_MAX66 = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN66 = -66'sd2147483648;

    typedef struct packed {
        logic [30:0]        depth_left;
        logic [30:0]        depth_right;
        logic signed [31:0] momentum_left;
        logic signed [31:0] momentum_right;
        logic signed [31:0] bed_left;
        logic signed [31:0] bed_right;
        logic signed [31:0] velocity_left;
        logic signed [31:0] velocity_right;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] height_update_left;
        logic signed [31:0] height_update_right;
        logic signed [31:0] flow_update_left;
        logic signed [31:0] flow_update_right;
        logic [30:0]        max_wave_speed;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic                dry;
        logic                zero;
        logic                wet_l;
        logic                wet_r;
        logic                small_gap;
        logic [30:0]         hl;
        logic [30:0]         hr;
        logic [30:0]         hroe;
        logic signed [31:0]  hul;
        logic signed [31:0]  hur;
        logic signed [31:0]  ul;
        logic signed [31:0]  ur;
        logic signed [31:0]  bd;
        logic signed [63:0]  pa;
        logic signed [63:0]  pb;
        logic signed [63:0]  pc;
        logic signed [63:0]  pd;
        logic signed [63:0]  pe;
        logic signed [63:0]  pf;
        logic signed [31:0]  xc;
        logic signed [31:0]  gbd;
        logic signed [31:0]  hhl;
        logic signed [31:0]  hhr;
        logic signed [31:0]  mu_l;
        logic signed [31:0]  mu_r;
        logic signed [31:0]  press_l;
        logic signed [31:0]  press_r;
        logic signed [31:0]  bath;
        logic signed [31:0]  fl1;
        logic signed [31:0]  fr1;
        logic signed [31:0]  df0;
        logic signed [31:0]  dd;
        logic signed [31:0]  df1;
        logic [SQ_STEPS-1:0] sl;
        logic [SQ_STEPS-1:0] sr;
        logic [SQ_STEPS-1:0] c;
        logic [SQ_STEPS:0]   den;
        logic signed [31:0]  ta;
        logic signed [31:0]  tb;
        logic signed [31:0]  num;
        logic                num_neg;
        logic [DIV_W-1:0]    num_mag;
        logic signed [31:0]  uroe;
        logic signed [31:0]  lam0;
        logic signed [31:0]  lam1;
        logic [30:0]         gaps;
        logic signed [31:0]  n0;
        logic signed [31:0]  n1;
        logic                n0_neg;
        logic                n1_neg;
        logic [DIV_W-1:0]    n0_mag;
        logic [DIV_W-1:0]    n1_mag;
        logic signed [31:0]  alpha0;
        logic signed [31:0]  alpha1;
        logic signed [31:0]  huw0;
        logic signed [31:0]  huw1;
        logic signed [31:0]  upd0;
        logic signed [31:0]  upd1;
        logic signed [31:0]  upd2;
        logic signed [31:0]  upd3;
        logic [30:0]         speed;
    } t_ctx;

    function automatic logic signed [31:0] f_sat32(input logic signed [65:0] v);
        if (v > S32_MAX66) begin
            return 32'sh7FFFFFFF;
        end else if (v < S32_MIN66) begin
            return 32'sh80000000;
        end
        return $signed(v[31:0]);
    endfunction

    function automatic logic signed [31:0] f_qadd(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return f_sat32(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] f_qsub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return f_sat32(66'(a) - 66'(b));
    endfunction

    function automatic logic signed [31:0] f_qneg(input logic signed [31:0] a);
        return f_sat32(-66'(a));
    endfunction

    function automatic logic signed [63:0] f_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    function automatic logic signed [31:0] f_qround(input logic signed [63:0] p);
        logic signed [65:0] t;
        t = (66'(p) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return f_sat32(t);
    endfunction

    function automatic logic [DIV_W-1:0] f_abs_mag(input logic signed [31:0] a);
        logic [31:0] m;
        m = a[31] ? (~a + 32'd1) : a;
        return DIV_W'(m) << FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] f_quot_sat(input logic neg,
                                                      input logic [DIV_W-1:0] q);
        if (neg) begin
            if (q >= DIV_W'(33'h080000000)) begin
                return 32'sh80000000;
            end
            return $signed(~q[31:0] + 32'd1);
        end
        if (q > DIV_W'(32'h7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end
        return $signed(q[31:0]);
    endfunction

endpackage

>>> hw/rtl/fwsw_sqrt.sv
// Pipelined integer square root of a fixed-point value, one root bit per stage
module fwsw_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [30:0]                    i_x,
    output logic [fwsw_pkg::SQ_STEPS-1:0]  o_root
);
    import fwsw_pkg::*;

    localparam int VW = 2 * SQ_STEPS;
    localparam int RW = SQ_STEPS + 2;

    logic [VW-1:0]       r_v    [SQ_STEPS];
    logic [RW-1:0]       r_rem  [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_root [SQ_STEPS];
    logic [VW-1:0]       n_v    [SQ_STEPS];
    logic [RW-1:0]       n_rem  [SQ_STEPS];
    logic [SQ_STEPS-1:0] n_root [SQ_STEPS];

    always_comb begin
        logic [VW-1:0]       v_in;
        logic [RW-1:0]       rem_in;
        logic [SQ_STEPS-1:0] root_in;
        logic [RW+1:0]       part;
        logic [RW+1:0]       trial;
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                v_in    = VW'(i_x) << FRAC_BITS;
                rem_in  = '0;
                root_in = '0;
            end else begin
                v_in    = r_v[k-1];
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
            end
            part  = {rem_in, v_in[VW-1 -: 2]};
            trial = (RW+2)'({root_in, 2'b01});
            if (part >= trial) begin
                n_rem[k]  = RW'(part - trial);
                n_root[k] = {root_in[SQ_STEPS-2:0], 1'b1};
            end else begin
                n_rem[k]  = RW'(part);
                n_root[k] = {root_in[SQ_STEPS-2:0], 1'b0};
            end
            n_v[k] = v_in << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_v[k]    <= n_v[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[SQ_STEPS-1];

endmodule

>>> hw/rtl/fwsw_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage
module fwsw_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fwsw_pkg::DIV_W-1:0]  i_dividend,
    input  logic [31:0]                 i_divisor,
    output logic [fwsw_pkg::DIV_W-1:0]  o_quot
);
    import fwsw_pkg::*;

    logic [31:0]      r_rem [DIV_W];
    logic [DIV_W-1:0] r_dq  [DIV_W];
    logic [31:0]      r_dvs [DIV_W];
    logic [31:0]      n_rem [DIV_W];
    logic [DIV_W-1:0] n_dq  [DIV_W];
    logic [31:0]      n_dvs [DIV_W];

    always_comb begin
        logic [31:0]      rem_in;
        logic [DIV_W-1:0] dq_in;
        logic [31:0]      dvs_in;
        logic [32:0]      part;
        logic             ge;
        for (int k = 0; k < DIV_W; k++) begin
            if (k == 0) begin
                rem_in = '0;
                dq_in  = i_dividend;
                dvs_in = i_divisor;
            end else begin
                rem_in = r_rem[k-1];
                dq_in  = r_dq[k-1];
                dvs_in = r_dvs[k-1];
            end
            part = {rem_in, dq_in[DIV_W-1]};
            ge   = (part >= {1'b0, dvs_in});
            if (ge) begin
                n_rem[k] = 32'(part - {1'b0, dvs_in});
            end else begin
                n_rem[k] = part[31:0];
            end
            n_dq[k]  = {dq_in[DIV_W-2:0], ge};
            n_dvs[k] = dvs_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_dq[k]  <= n_dq[k];
                r_dvs[k] <= n_dvs[k];
            end
        end
    end

    assign o_quot = r_dq[DIV_W-1];

endmodule

>>> hw/rtl/fwave_shallow_water_riemann.sv
// Top level: pipelined f-wave Riemann solver for one shallow water edge
// Pipeline from input transaction to result: 8 front stages, 24-stage root, 4 stages,
//   48-stage divider, 6 stages, 48-stage dividers, 5 tail stages.
// Throughput: one transaction per cycle; a stalled result holds the whole pipeline.
// Reset: clears all stage valid bits and loads gravity with 9.81.
`include "assert_macros.svh"

module fwave_shallow_water_riemann (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  fwsw_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output fwsw_pkg::t_out_item   o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [30:0]           i_cfg_data
);
    import fwsw_pkg::*;

    localparam logic signed [32:0] GAP_MIN33 = 33'(GAP_MIN);

    logic                en;
    logic [30:0]         r_gravity;
    logic signed [31:0]  g32;
    logic [PIPE_STG-1:0] r_vld;
    logic                flagged;
    logic                out_zero;

    t_ctx r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8;
    t_ctx n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8;
    t_ctx r_s10, r_s11, r_s12, r_s13, n_s10, n_s11, n_s12, n_s13;
    t_ctx r_s14, r_s15, r_s16, r_s17, r_s18, r_s19;
    t_ctx n_s14, n_s15, n_s16, n_s17, n_s18, n_s19;
    t_ctx r_s20, r_s21, r_s22, r_s23, n_s20, n_s21, n_s22, n_s23;
    t_ctx r_dq1 [SQ_STEPS];
    t_ctx r_dq2 [DIV_W];
    t_ctx r_dq3 [DIV_W];

    t_out_item r_out, n_out;

    logic [SQ_STEPS-1:0] sl, sr, cr;
    logic [DIV_W-1:0]    q_u, q_a0, q_a1;

    assign en          = !r_vld[PIPE_STG-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[PIPE_STG-1];
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
    assign g32         = $signed(32'(r_gravity));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RESET;
        end else if (i_cfg_valid) begin
            r_gravity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_STG-2:0], i_in_valid};
        end
    end

    // front: mirror, flux and source terms
    always_comb begin
        logic signed [31:0] bl_s, br_s;
        n_s1       = '0;
        n_s1.wet_l = i_in_data.bed_left[31];
        n_s1.wet_r = i_in_data.bed_right[31];
        if (n_s1.wet_l && n_s1.wet_r) begin
            n_s1.hl  = i_in_data.depth_left;
            n_s1.hr  = i_in_data.depth_right;
            n_s1.hul = i_in_data.momentum_left;
            n_s1.hur = i_in_data.momentum_right;
            n_s1.ul  = i_in_data.velocity_left;
            n_s1.ur  = i_in_data.velocity_right;
            bl_s     = i_in_data.bed_left;
            br_s     = i_in_data.bed_right;
        end else if (n_s1.wet_r) begin
            n_s1.hl  = i_in_data.depth_right;
            n_s1.hr  = i_in_data.depth_right;
            n_s1.hul = f_qneg(i_in_data.momentum_right);
            n_s1.hur = i_in_data.momentum_right;
            n_s1.ul  = f_qneg(i_in_data.velocity_right);
            n_s1.ur  = i_in_data.velocity_right;
            bl_s     = i_in_data.bed_right;
            br_s     = i_in_data.bed_right;
        end else begin
            n_s1.hl  = i_in_data.depth_left;
            n_s1.hr  = i_in_data.depth_left;
            n_s1.hul = i_in_data.momentum_left;
            n_s1.hur = f_qneg(i_in_data.momentum_left);
            n_s1.ul  = i_in_data.velocity_left;
            n_s1.ur  = f_qneg(i_in_data.velocity_left);
            bl_s     = i_in_data.bed_left;
            br_s     = i_in_data.bed_left;
        end
        n_s1.dry  = !n_s1.wet_l && !n_s1.wet_r;
        n_s1.zero = (n_s1.hl == '0) || (n_s1.hr == '0);
        n_s1.hroe = 31'((32'(n_s1.hl) + 32'(n_s1.hr)) >> 1);
        n_s1.bd   = f_qsub(bl_s, br_s);

        n_s2    = r_s1;
        n_s2.pa = f_mul(g32, $signed(32'(r_s1.hroe)));
        n_s2.pb = f_mul(g32, r_s1.bd);
        n_s2.pc = f_mul($signed(32'(r_s1.hl)), $signed(32'(r_s1.hl)));
        n_s2.pd = f_mul($signed(32'(r_s1.hr)), $signed(32'(r_s1.hr)));
        n_s2.pe = f_mul(r_s1.hul, r_s1.ul);
        n_s2.pf = f_mul(r_s1.hur, r_s1.ur);

        n_s3      = r_s2;
        n_s3.xc   = f_qround(r_s2.pa);
        n_s3.gbd  = f_qround(r_s2.pb);
        n_s3.hhl  = f_qround(r_s2.pc);
        n_s3.hhr  = f_qround(r_s2.pd);
        n_s3.mu_l = f_qround(r_s2.pe);
        n_s3.mu_r = f_qround(r_s2.pf);

        n_s4    = r_s3;
        n_s4.pa = f_mul(g32, r_s3.hhl);
        n_s4.pb = f_mul(g32, r_s3.hhr);
        n_s4.pc = f_mul(r_s3.gbd, $signed(32'(r_s3.hroe)));

        n_s5         = r_s4;
        n_s5.press_l = f_qround(r_s4.pa) >>> 1;
        n_s5.press_r = f_qround(r_s4.pb) >>> 1;
        n_s5.bath    = f_qround(r_s4.pc);

        n_s6     = r_s5;
        n_s6.fl1 = f_qadd(r_s5.mu_l, r_s5.press_l);
        n_s6.fr1 = f_qadd(r_s5.mu_r, r_s5.press_r);
        n_s6.df0 = f_qsub(r_s5.hur, r_s5.hul);

        n_s7    = r_s6;
        n_s7.dd = f_qsub(r_s6.fr1, r_s6.fl1);

        n_s8     = r_s7;
        n_s8.df1 = f_qsub(r_s7.dd, r_s7.bath);
    end

    fwsw_sqrt u_sqrt_l (.i_clk(i_clk), .i_en(en), .i_x(r_s8.hl), .o_root(sl));
    fwsw_sqrt u_sqrt_r (.i_clk(i_clk), .i_en(en), .i_x(r_s8.hr), .o_root(sr));
    fwsw_sqrt u_sqrt_c (.i_clk(i_clk), .i_en(en), .i_x(r_s8.xc[30:0]), .o_root(cr));

    // Roe velocity numerator and divisor
    always_comb begin
        n_s10     = r_dq1[SQ_STEPS-1];
        n_s10.sl  = sl;
        n_s10.sr  = sr;
        n_s10.c   = cr;
        n_s10.den = (SQ_STEPS+1)'(sl) + (SQ_STEPS+1)'(sr);
        n_s10.pa  = f_mul(n_s10.ul, $signed(32'(sl)));
        n_s10.pb  = f_mul(n_s10.ur, $signed(32'(sr)));

        n_s11    = r_s10;
        n_s11.ta = f_qround(r_s10.pa);
        n_s11.tb = f_qround(r_s10.pb);

        n_s12     = r_s11;
        n_s12.num = f_qadd(r_s11.ta, r_s11.tb);

        n_s13         = r_s12;
        n_s13.num_neg = r_s12.num[31];
        n_s13.num_mag = f_abs_mag(r_s12.num);
    end

    fwsw_div u_div_u (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_s13.num_mag),
        .i_divisor  (32'(r_s13.den)),
        .o_quot     (q_u)
    );

    // eigenvalues and wave strength numerators
    always_comb begin
        logic signed [32:0] gap;
        n_s14      = r_dq2[DIV_W-1];
        n_s14.uroe = f_quot_sat(n_s14.num_neg, q_u);

        n_s15      = r_s14;
        n_s15.lam0 = f_qsub(r_s14.uroe, $signed(32'(r_s14.c)));
        n_s15.lam1 = f_qadd(r_s14.uroe, $signed(32'(r_s14.c)));

        n_s16           = r_s15;
        gap             = 33'(r_s15.lam1) - 33'(r_s15.lam0);
        n_s16.small_gap = (gap <= GAP_MIN33);
        n_s16.gaps      = (gap > 33'sd2147483647) ? 31'h7FFFFFFF : gap[30:0];
        n_s16.pa        = f_mul(r_s15.lam1, r_s15.df0);
        n_s16.pb        = f_mul(r_s15.lam0, r_s15.df0);

        n_s17    = r_s16;
        n_s17.ta = f_qround(r_s16.pa);
        n_s17.tb = f_qround(r_s16.pb);

        n_s18    = r_s17;
        n_s18.n0 = f_qsub(r_s17.ta, r_s17.df1);
        n_s18.n1 = f_qsub(r_s17.df1, r_s17.tb);

        n_s19        = r_s18;
        n_s19.n0_neg = r_s18.n0[31];
        n_s19.n1_neg = r_s18.n1[31];
        n_s19.n0_mag = f_abs_mag(r_s18.n0);
        n_s19.n1_mag = f_abs_mag(r_s18.n1);
    end

    fwsw_div u_div_a0 (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_s19.n0_mag),
        .i_divisor  (32'(r_s19.gaps)),
        .o_quot     (q_a0)
    );

    fwsw_div u_div_a1 (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_s19.n1_mag),
        .i_divisor  (32'(r_s19.gaps)),
        .o_quot     (q_a1)
    );

    // net updates, wave speed and result selection
    always_comb begin
        logic signed [31:0] ll, lr, al, ar;
        logic               cl0, cl1, cr0, cr1;
        n_s20        = r_dq3[DIV_W-1];
        n_s20.alpha0 = f_quot_sat(n_s20.n0_neg, q_a0);
        n_s20.alpha1 = f_quot_sat(n_s20.n1_neg, q_a1);

        n_s21    = r_s20;
        n_s21.pa = f_mul(r_s20.alpha0, r_s20.lam0);
        n_s21.pb = f_mul(r_s20.alpha1, r_s20.lam1);

        n_s22      = r_s21;
        n_s22.huw0 = f_qround(r_s21.pa);
        n_s22.huw1 = f_qround(r_s21.pb);

        n_s23 = r_s22;
        cl0   = r_s22.wet_l && r_s22.lam0[31];
        cl1   = r_s22.wet_l && r_s22.lam1[31];
        cr0   = r_s22.wet_r && (r_s22.lam0 > 32'sd0);
        cr1   = r_s22.wet_r && (r_s22.lam1 > 32'sd0);
        n_s23.upd0 = f_qadd(cl0 ? r_s22.alpha0 : 32'sd0, cl1 ? r_s22.alpha1 : 32'sd0);
        n_s23.upd2 = f_qadd(cl0 ? r_s22.huw0 : 32'sd0, cl1 ? r_s22.huw1 : 32'sd0);
        n_s23.upd1 = f_qadd(cr0 ? r_s22.alpha0 : 32'sd0, cr1 ? r_s22.alpha1 : 32'sd0);
        n_s23.upd3 = f_qadd(cr0 ? r_s22.huw0 : 32'sd0, cr1 ? r_s22.huw1 : 32'sd0);
        ll = r_s22.lam0;
        lr = r_s22.lam1;
        if (r_s22.lam0[31] && r_s22.lam1[31]) begin
            lr = 32'sd0;
        end else if ((r_s22.lam0 > 32'sd0) && (r_s22.lam1 > 32'sd0)) begin
            ll = 32'sd0;
        end
        al = ll[31] ? f_qneg(ll) : ll;
        ar = lr[31] ? f_qneg(lr) : lr;
        n_s23.speed = (al > ar) ? al[30:0] : ar[30:0];

        n_out = '0;
        if (r_s23.dry) begin
            n_out.status = STATUS_OK;
        end else if (r_s23.zero) begin
            n_out.status = STATUS_ZERO_DEPTH;
        end else if (r_s23.small_gap) begin
            n_out.status = STATUS_SMALL_GAP;
        end else begin
            n_out.height_update_left  = r_s23.upd0;
            n_out.height_update_right = r_s23.upd1;
            n_out.flow_update_left    = r_s23.upd2;
            n_out.flow_update_right   = r_s23.upd3;
            n_out.max_wave_speed      = r_s23.speed;
            n_out.status              = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_s5  <= n_s5;
            r_s6  <= n_s6;
            r_s7  <= n_s7;
            r_s8  <= n_s8;
            r_dq1[0] <= r_s8;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_dq1[k] <= r_dq1[k-1];
            end
            r_s10 <= n_s10;
            r_s11 <= n_s11;
            r_s12 <= n_s12;
            r_s13 <= n_s13;
            r_dq2[0] <= r_s13;
            for (int k = 1; k < DIV_W; k++) begin
                r_dq2[k] <= r_dq2[k-1];
            end
            r_s14 <= n_s14;
            r_s15 <= n_s15;
            r_s16 <= n_s16;
            r_s17 <= n_s17;
            r_s18 <= n_s18;
            r_s19 <= n_s19;
            r_dq3[0] <= r_s19;
            for (int k = 1; k < DIV_W; k++) begin
                r_dq3[k] <= r_dq3[k-1];
            end
            r_s20 <= n_s20;
            r_s21 <= n_s21;
            r_s22 <= n_s22;
            r_s23 <= n_s23;
            r_out <= n_out;
        end
    end

    assign flagged  = o_out_valid && (o_out_data.status != STATUS_OK);
    assign out_zero = (o_out_data.height_update_left == 32'sd0)
                   && (o_out_data.height_update_right == 32'sd0)
                   && (o_out_data.flow_update_left == 32'sd0)
                   && (o_out_data.flow_update_right == 32'sd0)
                   && (o_out_data.max_wave_speed == 31'd0);

    `ASSERT_CLK(a_flag_zeroes, i_clk, i_rst_n, flagged |-> out_zero, "flagged result not zero")
    `ASSERT_CLK(a_enter, i_clk, i_rst_n, i_in_valid && o_in_ready |=> r_vld[0], "transaction lost")
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule
